FILE: src/ggf_pkg.sv
`default_nettype none
package ggf_pkg;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_RECIP_X = 3'd3;
  localparam logic [2:0] REG_RECIP_Y = 3'd4;
  localparam logic [2:0] REG_RECIP_Z = 3'd5;

  localparam int NumReads = 6;
  localparam int RdSelW = $clog2(NumReads);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } ggf_axis_e;

  typedef struct packed {
    logic              mem_wr;
    logic              addr_load;
    logic              rd_en;
    logic [RdSelW-1:0] rd_sel;
    logic              cap_minus;
    logic              cap_diff;
    logic              mul_en;
    ggf_axis_e         mul_axis;
    logic              sat_en;
    ggf_axis_e         sat_axis;
    logic              out_load;
  } ggf_cmd_t;

endpackage
`default_nettype wire

FILE: src/ggf_ctrl.sv
`default_nettype none
module ggf_ctrl
  import ggf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     kind_i,
  output logic          in_ready_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output ggf_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FINAL = 3'b100
  } state_e;

  localparam logic [2:0] LastPhase = 3'd7;

  state_e     state_q, state_d;
  logic [2:0] ph_q, ph_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_axis  = AXIS_X;
    cmd_o.sat_axis  = AXIS_X;
    cmd_o.mem_wr    = accept && (kind_i == KIND_WRITE);
    cmd_o.addr_load = accept && (kind_i == KIND_QUERY);
    if (state_q == S_RUN) begin
      cmd_o.rd_en     = (32'(ph_q) < NumReads);
      cmd_o.rd_sel    = RdSelW'(ph_q);
      cmd_o.cap_minus = ph_q[0] && (32'(ph_q) < NumReads);
      cmd_o.cap_diff  = !ph_q[0] && (ph_q != 3'd0);
      cmd_o.mul_en    = ph_q[0] && (ph_q >= 3'd3);
      cmd_o.sat_en    = !ph_q[0] && (ph_q >= 3'd4);
      case (ph_q)
        3'd3:    cmd_o.mul_axis = AXIS_X;
        3'd5:    cmd_o.mul_axis = AXIS_Y;
        default: cmd_o.mul_axis = AXIS_Z;
      endcase
      case (ph_q)
        3'd4:    cmd_o.sat_axis = AXIS_X;
        default: cmd_o.sat_axis = AXIS_Y;
      endcase
    end
    if (state_q == S_FINAL) begin
      cmd_o.out_load = out_free;
    end
  end

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_QUERY)) begin
          state_d = S_RUN;
          ph_d    = 3'd0;
        end
      end
      S_RUN: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == LastPhase) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/ggf_dpath.sv
`default_nettype none
module ggf_dpath
  import ggf_pkg::*;
#(
  parameter int MAX_DIM = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ggf_cmd_t           cmd_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [4:0]         x_index_i,
  input  wire logic [4:0]         y_index_i,
  input  wire logic [4:0]         z_index_i,
  input  wire logic signed [31:0] potential_value_i,
  output logic signed [31:0]      field_x_o,
  output logic signed [31:0]      field_y_o,
  output logic signed [31:0]      field_z_o,
  output logic                    saturated_o
);

  localparam int Depth = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(Depth);

  logic [5:0]  size_x_q, size_y_q, size_z_q;
  logic [31:0] recip_x_q, recip_y_q, recip_z_q;

  logic [31:0]        mem_q [Depth];
  logic [AW-1:0]      addr_q [NumReads];
  logic signed [31:0] rdata_q;
  logic signed [31:0] minus_q;
  logic signed [32:0] diff_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] wx_q, wy_q;
  logic               sat_acc_q;
  logic signed [31:0] fx_q, fy_q, fz_q;
  logic               sat_q;

  logic [5:0]         last_x, last_y, last_z;
  logic [5:0]         cx, cy, cz;
  logic [AW-1:0]      wr_addr, mem_addr;
  logic [31:0]        recip_sel;
  logic signed [32:0] recip_s;
  logic signed [31:0] sat_val;
  logic               sat_flag;

  function automatic logic [5:0] last_of(input logic [5:0] s);
    logic [5:0] l;
    if (s < 6'd2) begin
      l = 6'd1;
    end else if (32'(s) > 32'(MAX_DIM)) begin
      l = 6'(MAX_DIM - 1);
    end else begin
      l = s - 6'd1;
    end
    return l;
  endfunction

  function automatic logic [5:0] clamp(input logic [4:0] idx, input logic [5:0] last);
    logic [5:0] e;
    e = {1'b0, idx};
    return (e > last) ? last : e;
  endfunction

  function automatic logic [5:0] dec(input logic [5:0] c);
    return (c == 6'd0) ? 6'd0 : c - 6'd1;
  endfunction

  function automatic logic [5:0] inc(input logic [5:0] c, input logic [5:0] last);
    return (c >= last) ? last : c + 6'd1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
                                            input logic [5:0] z);
    return AW'(x) + AW'(MAX_DIM) * AW'(y) + AW'(MAX_DIM * MAX_DIM) * AW'(z);
  endfunction

  assign last_x = last_of(size_x_q);
  assign last_y = last_of(size_y_q);
  assign last_z = last_of(size_z_q);
  assign cx     = clamp(x_index_i, last_x);
  assign cy     = clamp(y_index_i, last_y);
  assign cz     = clamp(z_index_i, last_z);

  assign wr_addr  = addr_of(cx, cy, cz);
  assign mem_addr = cmd_i.mem_wr ? wr_addr : addr_q[cmd_i.rd_sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= 6'd32;
      size_y_q  <= 6'd32;
      size_z_q  <= 6'd32;
      recip_x_q <= 32'd65536;
      recip_y_q <= 32'd65536;
      recip_z_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X:  size_x_q  <= cfg_data_i[5:0];
        REG_SIZE_Y:  size_y_q  <= cfg_data_i[5:0];
        REG_SIZE_Z:  size_z_q  <= cfg_data_i[5:0];
        REG_RECIP_X: recip_x_q <= cfg_data_i;
        REG_RECIP_Y: recip_y_q <= cfg_data_i;
        REG_RECIP_Z: recip_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[mem_addr] <= potential_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q[0] <= addr_of(dec(cx), cy, cz);
      addr_q[1] <= addr_of(inc(cx, last_x), cy, cz);
      addr_q[2] <= addr_of(cx, dec(cy), cz);
      addr_q[3] <= addr_of(cx, inc(cy, last_y), cz);
      addr_q[4] <= addr_of(cx, cy, dec(cz));
      addr_q[5] <= addr_of(cx, cy, inc(cz, last_z));
    end
  end

  always_comb begin
    case (cmd_i.mul_axis)
      AXIS_X:  recip_sel = recip_x_q;
      AXIS_Y:  recip_sel = recip_y_q;
      AXIS_Z:  recip_sel = recip_z_q;
      default: recip_sel = '0;
    endcase
  end

  assign recip_s = $signed({1'b0, recip_sel});

  // floor of prod / 2^16, clipped to signed 32 bits
  always_comb begin
    sat_flag = !((&prod_q[65:47]) || !(|prod_q[65:47]));
    if (sat_flag) begin
      sat_val = prod_q[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_val = prod_q[47:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_minus) begin
      minus_q <= rdata_q;
    end
    if (cmd_i.cap_diff) begin
      diff_q <= 33'(minus_q) - 33'(rdata_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= 66'(diff_q) * 66'(recip_s);
    end
    if (cmd_i.sat_en) begin
      case (cmd_i.sat_axis)
        AXIS_X: begin
          wx_q      <= sat_val;
          sat_acc_q <= sat_flag;
        end
        default: begin
          wy_q      <= sat_val;
          sat_acc_q <= sat_acc_q | sat_flag;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      fx_q  <= wx_q;
      fy_q  <= wy_q;
      fz_q  <= sat_val;
      sat_q <= sat_acc_q | sat_flag;
    end
  end

  assign field_x_o   = fx_q;
  assign field_y_o   = fy_q;
  assign field_z_o   = fz_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

FILE: src/grid_gradient_field.sv
// Write item: stored in the grid, no result; ready stays high.
// Query item: six reads from the single-port grid memory, one per cycle, then a
// single 33x33 multiplier shared by the three axes; the result is registered.
// Ready drops while a query is in flight and returns once its result is loaded.
// Reset clears the control state and sets sizes to 32 and reciprocals to 1.0;
// grid contents are not cleared.
`default_nettype none
module grid_gradient_field
  import ggf_pkg::*;
#(
  parameter int MAX_DIM = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [4:0]         x_index_i,
  input  wire logic [4:0]         y_index_i,
  input  wire logic [4:0]         z_index_i,
  input  wire logic signed [31:0] potential_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      field_x_o,
  output logic signed [31:0]      field_y_o,
  output logic signed [31:0]      field_z_o,
  output logic                    saturated_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  ggf_cmd_t cmd;

  ggf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ggf_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .x_index_i         (x_index_i),
    .y_index_i         (y_index_i),
    .z_index_i         (z_index_i),
    .potential_value_i (potential_value_i),
    .field_x_o         (field_x_o),
    .field_y_o         (field_y_o),
    .field_z_o         (field_z_o),
    .saturated_o       (saturated_o)
  );

endmodule
`default_nettype wire

FILE: src/ggf_checker.sv
`default_nettype none
module ggf_checker
  import ggf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] field_x_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_x_o))
    else $error("result dropped or changed while stalled");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_QUERY) |=> !in_ready_o)
    else $error("item taken while a query is in flight");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_WRITE) |=> in_ready_o)
    else $error("write item stalled the input");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (kind_i == KIND_QUERY), 10))
    else $error("result without a query ten cycles earlier");

endmodule

bind grid_gradient_field ggf_checker u_ggf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .field_x_o   (field_x_o)
);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import ggf_pkg::*;

  localparam int MAX_DIM = 32;
  localparam int GRID_CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 114;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam int LIMIT = 400_000;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [31:0] pot;
    logic        has_expected;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic        es;
  } grid_item_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        sat;
  } field_t;

  typedef logic [5:0][14:0] nbr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = KIND_WRITE;
  logic [4:0]  x_index_i = '0;
  logic [4:0]  y_index_i = '0;
  logic [4:0]  z_index_i = '0;
  logic [31:0] potential_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] field_x_o;
  logic [31:0] field_y_o;
  logic [31:0] field_z_o;
  logic        saturated_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  grid_gradient_field dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .x_index_i,
    .y_index_i,
    .z_index_i,
    .potential_value_i,
    .out_valid_o,
    .out_ready_i,
    .field_x_o,
    .field_y_o,
    .field_z_o,
    .saturated_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  logic signed [31:0] grid_copy [GRID_CELLS];
  bit                 cell_written [GRID_CELLS];
  logic [5:0]         size_cfg [3] = '{6'd32, 6'd32, 6'd32};
  logic [31:0]        recip_cfg [3] = '{32'd65536, 32'd65536, 32'd65536};
  field_t             field_expect_q [$];
  logic [2:0]         reg_order [8] = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_RECIP_X,
                                        REG_RECIP_Y, REG_RECIP_Z, REG_SPARE_6, REG_SPARE_7};

  int items_sent = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  grid_item_t directed_rows [16] = '{
    '{KIND_WRITE, 5'd0, 5'd0, 5'd0, 32'h0001_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd1, 5'd0, 5'd0, 32'h0003_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd0, 5'd1, 5'd0, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd0, 5'd0, 5'd1, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_QUERY, 5'd0, 5'd0, 5'd0, 32'hA5A5_A5A5, 1'b1,
      32'hFFFE_0000, 32'h0002_0000, 32'h0001_0000, 1'b0},
    '{KIND_WRITE, 5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd30, 5'd31, 5'd31, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd31, 5'd30, 5'd31, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd31, 5'd31, 5'd30, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_QUERY, 5'd31, 5'd31, 5'd31, 32'h0, 1'b1,
      32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1},
    '{KIND_WRITE, 5'd31, 5'd31, 5'd31, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_QUERY, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 1'b1,
      32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1},
    '{KIND_WRITE, 5'd2, 5'd0, 5'd0, 32'h1234_5678, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd1, 5'd1, 5'd0, 32'hDEAD_BEEF, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_WRITE, 5'd1, 5'd0, 5'd1, 32'h0000_8001, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{KIND_QUERY, 5'd1, 5'd0, 5'd0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0}
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int eff_dim(logic [5:0] s);
    if (s < 6'd2) return 2;
    if (s > 6'(MAX_DIM)) return MAX_DIM;
    return int'(s);
  endfunction

  function automatic int clamp_dim(int v, int n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  function automatic logic [14:0] cell_addr(int x, int y, int z);
    return 15'(x + MAX_DIM * (y + MAX_DIM * z));
  endfunction

  // minus and plus neighbour of each axis, clamped into the grid in use
  function automatic nbr_t neighbours(logic [4:0] xi, logic [4:0] yi, logic [4:0] zi);
    int   nx, ny, nz, x, y, z;
    nbr_t n;
    nx = eff_dim(size_cfg[0]);
    ny = eff_dim(size_cfg[1]);
    nz = eff_dim(size_cfg[2]);
    x = clamp_dim(int'(xi), nx);
    y = clamp_dim(int'(yi), ny);
    z = clamp_dim(int'(zi), nz);
    n[0] = cell_addr(clamp_dim(x - 1, nx), y, z);
    n[1] = cell_addr(clamp_dim(x + 1, nx), y, z);
    n[2] = cell_addr(x, clamp_dim(y - 1, ny), z);
    n[3] = cell_addr(x, clamp_dim(y + 1, ny), z);
    n[4] = cell_addr(x, y, clamp_dim(z - 1, nz));
    n[5] = cell_addr(x, y, clamp_dim(z + 1, nz));
    return n;
  endfunction

  // floor(diff * recip / 2^16), clipped to 32 bits; bit 32 flags the clip
  function automatic logic [32:0] scale_axis(longint diff, logic [31:0] recip);
    logic [63:0] mag, prod, q;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, recip};
    q = prod >> 16;
    if (diff >= 0) begin
      if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
    end
    if (prod[15:0] != 16'd0) q = q + 64'd1;
    if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'd0 - q[31:0]};
  endfunction

  function automatic field_t predict_field(logic [4:0] xi, logic [4:0] yi, logic [4:0] zi);
    nbr_t        n;
    longint      d [3];
    logic [32:0] s [3];
    field_t      f;
    n = neighbours(xi, yi, zi);
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'(grid_copy[n[2*k]]) - longint'(grid_copy[n[2*k+1]]);
      s[k] = scale_axis(d[k], recip_cfg[k]);
    end
    f.fx = s[0][31:0];
    f.fy = s[1][31:0];
    f.fz = s[2][31:0];
    f.sat = s[0][32] | s[1][32] | s[2][32];
    return f;
  endfunction

  function automatic logic [31:0] pick_potential();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_recip();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd65536;
      3: return $urandom;
      default: return 32'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  function automatic logic [4:0] pick_index(int n);
    case ($urandom_range(0, 7))
      0: return 5'($urandom_range(0, 31));
      1: return 5'd0;
      2: return 5'(n - 1);
      3: return 5'd31;
      4, 5: return 5'($urandom_range(0, ((n < 6) ? n : 6) - 1));
      default: return 5'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic send_item(grid_item_t it);
    int          gap;
    logic [14:0] a;
    field_t      f;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    if (it.kind == KIND_WRITE) begin
      a = cell_addr(clamp_dim(int'(it.x), eff_dim(size_cfg[0])),
                    clamp_dim(int'(it.y), eff_dim(size_cfg[1])),
                    clamp_dim(int'(it.z), eff_dim(size_cfg[2])));
      grid_copy[a] = it.pot;
      cell_written[a] = 1'b1;
    end else begin
      if (it.has_expected) f = {it.ex, it.ey, it.ez, it.es};
      else f = predict_field(it.x, it.y, it.z);
      field_expect_q.push_back(f);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    x_index_i <= it.x;
    y_index_i <= it.y;
    z_index_i <= it.z;
    potential_value_i <= it.pot;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
  endtask

  // fill any unwritten neighbour first, then query
  task automatic issue_query();
    logic [4:0] qx, qy, qz;
    nbr_t       cells;
    grid_item_t it;
    qx = pick_index(eff_dim(size_cfg[0]));
    qy = pick_index(eff_dim(size_cfg[1]));
    qz = pick_index(eff_dim(size_cfg[2]));
    cells = neighbours(qx, qy, qz);
    for (int k = 0; k < 6; k++) begin
      if (!cell_written[cells[k]]) begin
        it = '0;
        it.kind = KIND_WRITE;
        it.x = cells[k][4:0];
        it.y = cells[k][9:5];
        it.z = cells[k][14:10];
        it.pot = pick_potential();
        send_item(it);
      end
    end
    it = '0;
    it.kind = KIND_QUERY;
    it.x = qx;
    it.y = qy;
    it.z = qz;
    it.pot = $urandom;
    send_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (field_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic configure(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    logic [31:0] data [8];
    data[0] = {26'($urandom), sx};
    data[1] = {26'($urandom), sy};
    data[2] = {26'($urandom), sz};
    data[3] = rx;
    data[4] = ry;
    data[5] = rz;
    data[6] = $urandom;
    data[7] = $urandom;
    for (int k = 0; k < 8; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_order[k];
      cfg_data_i <= data[k];
      @(posedge clk_i);
      case (reg_order[k])
        REG_SIZE_X: size_cfg[0] = data[k][5:0];
        REG_SIZE_Y: size_cfg[1] = data[k][5:0];
        REG_SIZE_Z: size_cfg[2] = data[k][5:0];
        REG_RECIP_X: recip_cfg[0] = data[k];
        REG_RECIP_Y: recip_cfg[1] = data[k];
        REG_RECIP_Z: recip_cfg[2] = data[k];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int         goal;
    grid_item_t it;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    settle();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: configure(6'd2, 6'd2, 6'd2, 32'd65536, 32'd65536, 32'd65536);
        1: configure(6'd0, 6'd1, 6'd63, 32'd0, 32'hFFFF_FFFF, 32'd1);
        2: begin
          configure(6'd32, 6'd32, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          hold_requests++;
        end
        3: configure(6'd31, 6'd17, 6'd5, 32'($urandom_range(0, 32'h3FFFF)),
                     32'($urandom_range(0, 32'h3FFFF)), 32'($urandom_range(0, 32'h3FFFF)));
        default: configure(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), pick_recip(), pick_recip(), pick_recip());
      endcase
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          issue_query();
        end else begin
          it = '0;
          it.kind = KIND_WRITE;
          it.x = 5'($urandom_range(0, 31));
          it.y = 5'($urandom_range(0, 31));
          it.z = 5'($urandom_range(0, 31));
          it.pot = pick_potential();
          send_item(it);
        end
      end
      settle();
    end
    if (mismatch_count == 0) begin
      $display("grid_gradient_field regression: pass");
    end else begin
      $display("grid_gradient_field regression: fail");
    end
    $finish;
  end

  initial begin : sink
    int mode, span;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_served != hold_requests) begin
          hold_served++;
          out_ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    field_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (field_expect_q.size() == 0) begin
        $error("result with no query waiting");
        mismatch_count++;
      end else begin
        want = field_expect_q.pop_front();
        if (field_x_o !== want.fx) begin
          $error("field_x: expected %h, got %h", want.fx, field_x_o);
          mismatch_count++;
        end
        if (field_y_o !== want.fy) begin
          $error("field_y: expected %h, got %h", want.fy, field_y_o);
          mismatch_count++;
        end
        if (field_z_o !== want.fz) begin
          $error("field_z: expected %h, got %h", want.fz, field_z_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %h, got %h", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("grid_gradient_field regression: fail");
    $finish;
  end

endmodule
